[rtl/genome_population_table_top_assert.svh]
// Assertion macros used by the checker of the genome population table.
`ifndef GENOME_POPULATION_TABLE_TOP_ASSERT_SVH
`define GENOME_POPULATION_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPT_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GPT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gpt_pkg.sv]
// ----------------------------------------------------------------------------
// Genome population table package
// Sizes, codes and word types shared by the population table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gpt_pkg;

  // Table capacity and the widths that follow from it.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TRI_W    = $clog2(CAPACITY * (CAPACITY + 1) / 2 + 1);
  localparam int LHS_W    = 16 + TRI_W;

  // Fitness of -1.0 in Q16.16.
  localparam logic signed [31:0] FIT_MINUS_ONE = -32'sd65536;

  // Configuration register indexes.
  localparam logic CFG_IDX_LIMIT = 1'b0;
  localparam logic CFG_IDX_MODE  = 1'b1;

  // Selection modes.
  localparam logic [1:0] MODE_RANDOM = 2'd0;
  localparam logic [1:0] MODE_BEST   = 2'd1;
  localparam logic [1:0] MODE_RANK   = 2'd2;

  typedef enum logic [1:0] {
    OP_STORE  = 2'd0,
    OP_SELECT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_NEW       = 4'd0,
    ST_OVERWRITE = 4'd1,
    ST_REPLACED  = 4'd2,
    ST_REJECTED  = 4'd3,
    ST_SELECTED  = 4'd4,
    ST_EMPTY_REG = 4'd5,
    ST_EMPTY     = 4'd6,
    ST_CLEARED   = 4'd7,
    ST_ERROR     = 4'd8
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FIT_WR,
    S_REMOVE,
    S_INSERT,
    S_MOD,
    S_BEST,
    S_RANK_I,
    S_RANK_J,
    S_RANK_K,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         robot_num;
    logic [31:0]        gene_id;
    logic signed [31:0] fitness;
    logic [15:0]        random_draw;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [3:0]         payload_slot;
    logic [9:0]         sel_robot_num;
    logic [31:0]        sel_gene_id;
    logic signed [31:0] sel_fitness;
    logic [4:0]         entry_count;
  } out_word_t;

  // One table entry.
  typedef struct packed {
    logic [9:0]         robot;
    logic [31:0]        gene;
    logic signed [31:0] fitness;
    logic [IDX_W-1:0]   slot;
  } entry_t;

  // Commands from the sequencer to the entry table.
  typedef struct packed {
    logic             wr_fit;
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] rd_addr;
    entry_t           ent;
  } tbl_ctrl_t;

endpackage

`default_nettype wire

[rtl/gpt_table.sv]
// ----------------------------------------------------------------------------
// Genome population entry table
// Key-ordered entry registers with one read port, an insert shift, a remove
// shift and a fitness write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpt_table import gpt_pkg::*; (
  input  wire logic      clk_i,
  input  wire tbl_ctrl_t ctrl_i,
  output entry_t         rd_ent_o
);

  entry_t ent_q [CAPACITY];

  // Read port at the address chosen by the sequencer.
  assign rd_ent_o = ent_q[ctrl_i.rd_addr];

  // Each entry takes its neighbour on a shift, or the new data or fitness at the position.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_ent
    logic at_pos, above_pos;
    assign at_pos    = (ctrl_i.pos == IDX_W'(k));
    assign above_pos = (IDX_W'(k) > ctrl_i.pos);

    always_ff @(posedge clk_i) begin
      if (ctrl_i.ins) begin
        if (at_pos) begin
          ent_q[k] <= ctrl_i.ent;
        end
        if (k > 0) begin
          if (above_pos) begin
            ent_q[k] <= ent_q[(k > 0) ? k - 1 : 0];
          end
        end
      end else if (ctrl_i.rem) begin
        if (k < CAPACITY - 1) begin
          if (at_pos || above_pos) begin
            ent_q[k] <= ent_q[(k < CAPACITY - 1) ? k + 1 : k];
          end
        end
      end else if (ctrl_i.wr_fit && at_pos) begin
        ent_q[k].fitness <= ctrl_i.ent.fitness;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/genome_population_table_top.sv]
// ----------------------------------------------------------------------------
// Genome population table
// Key-ordered genome table with replace-worst storage and mode-driven
// selection, run by a small sequencer over one entry read port.
// ----------------------------------------------------------------------------
// Use: an operation word enters on in_valid_i / in_stall_o and one result word
// leaves on out_valid_o / out_stall_i for every accepted word. Configuration
// words (population limit, selection mode) enter on cfg_valid_i / cfg_ready_o
// and are taken at any time; they should be written while the block is idle.
// The block handles one word at a time and holds in_stall_o high meanwhile.
// Steps per word, with n entries in the table: clear or an empty select go
// straight to the result; store scans every entry through the read port, then
// decides and takes the fitness write, removal and insertion steps as needed;
// random select takes a 16-step restoring remainder of the draw by n; best
// select scans every entry; rank select counts each candidate's rank over all
// entries through the single read port. A finished result waits in the output
// register while the receiver stalls; the next word is accepted but its result
// is held back until the register is free. Reset empties the table and sets the
// limit to 16 and the mode to random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module genome_population_table_top import gpt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic      cfg_index_i,
  input  wire logic [4:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [4:0]         limit_q;
  logic [1:0]         mode_q;
  logic [CNT_W-1:0]   count_q;
  logic [1:0]         op_q;
  logic [9:0]         robot_q;
  logic [31:0]        gene_q;
  logic signed [31:0] fit_q;
  logic [15:0]        draw_q;
  status_e            status_q;
  logic [IDX_W-1:0]   slot_q;
  logic [CNT_W-1:0]   k_q;
  logic [3:0]         bit_q;
  logic               found_q;
  logic [IDX_W-1:0]   idx_q;
  logic [IDX_W-1:0]   islot_q;
  logic [IDX_W-1:0]   w_q;
  logic [IDX_W-1:0]   wslot_q;
  logic signed [31:0] wfit_q;
  logic [CNT_W-1:0]   p_q;
  logic [CAPACITY-1:0] used_q;
  logic signed [31:0] best_q;
  logic [IDX_W-1:0]   sel_q;
  logic               have_q;
  logic [CNT_W:0]     rem_q;
  logic [CNT_W-1:0]   i_q;
  logic [TRI_W-1:0]   tri_q;
  logic [LHS_W-1:0]   lhs_q;
  logic [CNT_W-1:0]   j_q;
  logic signed [31:0] fj_q;
  logic [CNT_W-1:0]   rank_q;
  out_word_t          out_q;
  logic               out_valid_q;

  tbl_ctrl_t  tbl_ctrl;
  entry_t     rd_ent;

  logic             accept;
  logic             out_free;
  logic [CNT_W-1:0] lim_eff;
  logic             below_lim;
  logic             beats_worst;
  logic             last_k;
  logic             key_eq, key_lt;
  logic [IDX_W-1:0] free_slot;
  logic [CNT_W:0]   rem_shift;
  logic [LHS_W-1:0] rank_bound;
  logic             rank_inc;
  logic [CNT_W-1:0] rank_final;
  logic [TRI_W-1:0] total;

  gpt_table u_table (
    .clk_i    (clk_i),
    .ctrl_i   (tbl_ctrl),
    .rd_ent_o (rd_ent)
  );

  // Handshake terms.
  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Effective population limit, kept between one and the capacity.
  always_comb begin
    if (limit_q == 5'd0) begin
      lim_eff = CNT_W'(1);
    end else if (int'(limit_q) > CAPACITY) begin
      lim_eff = CNT_W'(CAPACITY);
    end else begin
      lim_eff = CNT_W'(limit_q);
    end
  end

  assign below_lim   = (count_q < lim_eff);
  assign beats_worst = (wfit_q < fit_q);
  assign last_k      = ((k_q + CNT_W'(1)) == count_q);
  assign key_eq      = (rd_ent.robot == robot_q) && (rd_ent.gene == gene_q);
  assign key_lt      = (rd_ent.robot < robot_q) ||
                       ((rd_ent.robot == robot_q) && (rd_ent.gene < gene_q));

  // Lowest slot not tagged on any entry.
  always_comb begin
    free_slot = '0;
    for (int s = CAPACITY - 1; s >= 0; s--) begin
      if (!used_q[s]) begin
        free_slot = IDX_W'(s);
      end
    end
  end

  // One step of the restoring remainder of the draw by the entry count.
  assign rem_shift = {rem_q[CNT_W-1:0], draw_q[4'd15 - bit_q]};

  // Rank bound 65535 * tri, and the triangular total of the count.
  assign rank_bound = {tri_q, 16'd0} - LHS_W'(tri_q);
  assign total      = TRI_W'(((2 * CNT_W)'(count_q) *
                              (2 * CNT_W)'(count_q + CNT_W'(1))) >> 1);

  // Rank counting: entries below the candidate, ties broken by key order.
  assign rank_inc   = (rd_ent.fitness < fj_q) || ((rd_ent.fitness == fj_q) && (k_q < j_q));
  assign rank_final = rank_q + CNT_W'(rank_inc);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_word_i.opcode)
            OP_STORE:  state_d = (count_q == '0) ? S_DECIDE : S_SCAN;
            OP_SELECT: begin
              if (mode_q > MODE_RANK || count_q == '0) begin
                state_d = S_FINISH;
              end else if (mode_q == MODE_RANDOM) begin
                state_d = S_MOD;
              end else if (mode_q == MODE_BEST) begin
                state_d = S_BEST;
              end else begin
                state_d = S_RANK_I;
              end
            end
            default: state_d = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        if (last_k) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (below_lim) begin
          state_d = found_q ? S_FIT_WR : S_INSERT;
        end else if (count_q == '0 || !beats_worst) begin
          state_d = S_FINISH;
        end else begin
          state_d = found_q ? S_FIT_WR : S_REMOVE;
        end
      end
      S_FIT_WR: begin
        state_d = (status_q == ST_REPLACED && idx_q != w_q) ? S_REMOVE : S_FINISH;
      end
      S_REMOVE: state_d = found_q ? S_FINISH : S_INSERT;
      S_INSERT: state_d = S_FINISH;
      S_MOD: begin
        if (bit_q == 4'd15) begin
          state_d = S_FINISH;
        end
      end
      S_BEST: begin
        if (last_k) begin
          state_d = S_FINISH;
        end
      end
      S_RANK_I: begin
        if (!((i_q + CNT_W'(1)) < count_q && lhs_q > rank_bound)) begin
          state_d = S_RANK_J;
        end
      end
      S_RANK_J: state_d = S_RANK_K;
      S_RANK_K: begin
        if (last_k) begin
          if (rank_final == i_q || (j_q + CNT_W'(1)) == count_q) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_RANK_J;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Table commands and read address.
  always_comb begin
    tbl_ctrl             = '0;
    tbl_ctrl.ent.robot   = robot_q;
    tbl_ctrl.ent.gene    = gene_q;
    tbl_ctrl.ent.fitness = fit_q;
    tbl_ctrl.ent.slot    = slot_q;
    tbl_ctrl.rd_addr     = k_q[IDX_W-1:0];
    case (state_q)
      S_FIT_WR: begin
        tbl_ctrl.wr_fit = 1'b1;
        tbl_ctrl.pos    = idx_q;
      end
      S_REMOVE: begin
        tbl_ctrl.rem = 1'b1;
        tbl_ctrl.pos = w_q;
      end
      S_INSERT: begin
        tbl_ctrl.ins = 1'b1;
        tbl_ctrl.pos = p_q[IDX_W-1:0];
      end
      S_RANK_J: tbl_ctrl.rd_addr = j_q[IDX_W-1:0];
      S_FINISH: tbl_ctrl.rd_addr = sel_q;
      default:  tbl_ctrl.rd_addr = k_q[IDX_W-1:0];
    endcase
  end

  // State, configuration and count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= 5'd16;
      mode_q      <= MODE_RANDOM;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_IDX_LIMIT) begin
          limit_q <= cfg_data_i;
        end else begin
          mode_q <= cfg_data_i[1:0];
        end
      end
      if (accept && in_word_i.opcode == OP_CLEAR) begin
        count_q <= '0;
      end else if (state_q == S_REMOVE) begin
        count_q <= count_q - CNT_W'(1);
      end else if (state_q == S_INSERT) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (state_q == S_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q     <= in_word_i.opcode;
        robot_q  <= in_word_i.robot_num;
        gene_q   <= in_word_i.gene_id;
        fit_q    <= in_word_i.fitness;
        draw_q   <= in_word_i.random_draw;
        lhs_q    <= LHS_W'(in_word_i.random_draw) * LHS_W'(total);
        k_q      <= '0;
        bit_q    <= '0;
        found_q  <= 1'b0;
        p_q      <= '0;
        used_q   <= '0;
        best_q   <= FIT_MINUS_ONE;
        have_q   <= 1'b0;
        rem_q    <= '0;
        i_q      <= '0;
        tri_q    <= TRI_W'(1);
        j_q      <= '0;
        rank_q   <= '0;
        slot_q   <= '0;
        sel_q    <= '0;
        status_q <= ST_ERROR;
        if (in_word_i.opcode == OP_CLEAR) begin
          status_q <= ST_CLEARED;
        end else if (in_word_i.opcode == OP_SELECT && mode_q <= MODE_RANK &&
                     count_q == '0) begin
          status_q <= (mode_q == MODE_RANDOM) ? ST_EMPTY_REG : ST_EMPTY;
        end
      end
      S_SCAN: begin
        if (key_eq) begin
          found_q <= 1'b1;
          idx_q   <= k_q[IDX_W-1:0];
          islot_q <= rd_ent.slot;
        end
        if (key_lt) begin
          p_q <= p_q + CNT_W'(1);
        end
        used_q[rd_ent.slot] <= 1'b1;
        if (k_q == '0 || rd_ent.fitness < wfit_q) begin
          w_q     <= k_q[IDX_W-1:0];
          wfit_q  <= rd_ent.fitness;
          wslot_q <= rd_ent.slot;
        end
        k_q <= k_q + CNT_W'(1);
      end
      S_DECIDE: begin
        if (below_lim) begin
          status_q <= found_q ? ST_OVERWRITE : ST_NEW;
          slot_q   <= found_q ? islot_q : free_slot;
        end else if (count_q == '0 || !beats_worst) begin
          status_q <= ST_REJECTED;
        end else begin
          status_q <= ST_REPLACED;
          slot_q   <= found_q ? islot_q : wslot_q;
        end
      end
      S_REMOVE: begin
        // Keys below the new one lose one place when the worst sat among them.
        if ({1'b0, w_q} < p_q) begin
          p_q <= p_q - CNT_W'(1);
        end
      end
      S_MOD: begin
        if (rem_shift >= {1'b0, count_q}) begin
          rem_q <= rem_shift - {1'b0, count_q};
        end else begin
          rem_q <= rem_shift;
        end
        bit_q <= bit_q + 4'd1;
        if (bit_q == 4'd15) begin
          have_q <= 1'b1;
          if (rem_shift >= {1'b0, count_q}) begin
            sel_q <= IDX_W'(rem_shift - {1'b0, count_q});
          end else begin
            sel_q <= IDX_W'(rem_shift);
          end
        end
      end
      S_BEST: begin
        if (rd_ent.fitness > best_q) begin
          best_q <= rd_ent.fitness;
          sel_q  <= k_q[IDX_W-1:0];
          have_q <= 1'b1;
        end
        k_q <= k_q + CNT_W'(1);
      end
      S_RANK_I: begin
        if ((i_q + CNT_W'(1)) < count_q && lhs_q > rank_bound) begin
          i_q   <= i_q + CNT_W'(1);
          tri_q <= tri_q + TRI_W'(i_q) + TRI_W'(2);
        end
      end
      S_RANK_J: begin
        fj_q   <= rd_ent.fitness;
        k_q    <= '0;
        rank_q <= '0;
      end
      S_RANK_K: begin
        rank_q <= rank_final;
        k_q    <= k_q + CNT_W'(1);
        if (last_k) begin
          if (rank_final == i_q) begin
            sel_q  <= j_q[IDX_W-1:0];
            have_q <= 1'b1;
          end
          j_q <= j_q + CNT_W'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_q.entry_count <= 5'(count_q);
          if (have_q) begin
            out_q.status        <= ST_SELECTED;
            out_q.payload_slot  <= 4'(rd_ent.slot);
            out_q.sel_robot_num <= rd_ent.robot;
            out_q.sel_gene_id   <= rd_ent.gene;
            out_q.sel_fitness   <= rd_ent.fitness;
          end else begin
            out_q.status        <= status_q;
            out_q.sel_robot_num <= '0;
            out_q.sel_gene_id   <= '0;
            out_q.sel_fitness   <= '0;
            if (op_q == OP_STORE && status_q <= ST_REPLACED) begin
              out_q.payload_slot <= 4'(slot_q);
            end else begin
              out_q.payload_slot <= '0;
            end
          end
        end
      end
      default: begin
        k_q <= k_q;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/gpt_checker.sv]
// ----------------------------------------------------------------------------
// Genome population table checker
// Port-level assertions on the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "genome_population_table_top_assert.svh"

module gpt_checker import gpt_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_word_t out_word_o
);

  // A word held by the receiver stays on the port unchanged.
  `GPT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "result word changed while stalled")

  // Once a word is taken the block is busy in the next cycle.
  `GPT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "block took a second word at once")

  // The reported count never exceeds the table capacity.
  `GPT_ASSERT_SAME(a_count_bound, out_valid_o, int'(out_word_o.entry_count) <= CAPACITY, "entry count above capacity")

  // A cleared table reports no entries.
  `GPT_ASSERT_SAME(a_clear_empty, out_valid_o && out_word_o.status == ST_CLEARED, out_word_o.entry_count == 5'd0, "clear left entries")

endmodule

bind genome_population_table_top gpt_checker u_gpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
